FILE: sv/pru_pkg.sv
`default_nettype none

package pru_pkg;

	// Field widths fixed by the interface
	localparam int PIXEL_W = 32;
	localparam int ADDR_W = 28;
	localparam int SIDE_CFG_W = 12;
	localparam int FACT_CFG_W = 4;
	localparam int GAP_CFG_W = 3;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W = 3;

	// Default parameter values
	localparam int PIXEL_BITS_DEF = 32;
	localparam int MAX_SIDE_DEF = 2048;
	localparam int MAX_FACTOR_DEF = 8;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_FACTOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_FACTOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_GAP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_GAP = 3'd5;

	// Register reset values
	localparam logic [SIDE_CFG_W-1:0] SRC_WIDTH_RST = 12'd320;
	localparam logic [SIDE_CFG_W-1:0] SRC_HEIGHT_RST = 12'd200;
	localparam logic [FACT_CFG_W-1:0] X_FACTOR_RST = 4'd2;
	localparam logic [FACT_CFG_W-1:0] Y_FACTOR_RST = 4'd2;
	localparam logic [GAP_CFG_W-1:0] X_GAP_RST = 3'd0;
	localparam logic [GAP_CFG_W-1:0] Y_GAP_RST = 3'd0;

	// Controller to datapath
	typedef struct packed {
		logic capture;   // take the input item
		logic prep;      // clamp config, form factor products
		logic base;      // form block base address, advance counters
		logic emit;      // load the next write into the output register
	} pru_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic err;       // both factors are one
		logic none;      // a gap swallows the whole block
		logic at_last;   // the next write is the final one of this item
		logic out_free;  // output register can take a write this cycle
	} pru_sts_t;

endpackage

`default_nettype wire

FILE: sv/pru_ctrl.sv
`default_nettype none

module pru_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire pru_pkg::pru_sts_t sts,
	output pru_pkg::pru_cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PREP = 2'd1;
	localparam logic [1:0] ST_BASE = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_BASE;
			end
			ST_BASE: begin
				cmd.base = 1'b1;
				if (!sts.err && sts.none) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.at_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	// An item is taken only from idle, and setup always follows
	a_capture_prep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.prep)
		else $error("setup did not follow item capture");

	a_prep_base: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.prep |=> cmd.base)
		else $error("base step did not follow setup");

	a_no_emit_in_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !in_ready && !cmd.prep && !cmd.base)
		else $error("write issued outside the emit phase");
`endif

endmodule

`default_nettype wire

FILE: sv/pru_datapath.sv
`default_nettype none

module pru_datapath #(
	parameter int PIXEL_BITS = pru_pkg::PIXEL_BITS_DEF,
	parameter int MAX_SIDE = pru_pkg::MAX_SIDE_DEF,
	parameter int MAX_FACTOR = pru_pkg::MAX_FACTOR_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pru_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pru_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [pru_pkg::PIXEL_W-1:0]       pixel_in,
	input  wire logic                              out_ready,
	output logic                                   out_valid,
	output logic [pru_pkg::ADDR_W-1:0]             dest_addr,
	output logic [pru_pkg::PIXEL_W-1:0]            pixel_out,
	output logic                                   is_error,
	output logic                                   last,
	input  wire pru_pkg::pru_cmd_t                 cmd,
	output pru_pkg::pru_sts_t                      sts
);

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CNT_W = $clog2(MAX_SIDE);
	localparam int FACT_W = $clog2(MAX_FACTOR + 1);
	localparam int DW_W = $clog2(MAX_SIDE * MAX_FACTOR + 1);
	localparam int STEP_W = $clog2(MAX_SIDE * MAX_FACTOR * MAX_FACTOR + 1);
	localparam int AW = pru_pkg::ADDR_W;
	localparam logic [pru_pkg::PIXEL_W-1:0] PIX_MASK =
		pru_pkg::PIXEL_W'((64'd1 << PIXEL_BITS) - 64'd1);

	// Configuration registers
	logic [pru_pkg::SIDE_CFG_W-1:0] src_width_q, src_height_q;
	logic [pru_pkg::FACT_CFG_W-1:0] x_factor_q, y_factor_q;
	logic [pru_pkg::GAP_CFG_W-1:0]  x_gap_q, y_gap_q;

	// Frame position
	logic [CNT_W-1:0]  col_q, row_q;
	logic [AW-1:0]     row_base_q;

	// Per-item working registers
	logic [pru_pkg::PIXEL_W-1:0] pix_q;
	logic [SIDE_W-1:0] w_q, h_q;
	logic [FACT_W-1:0] yf_q, xi_q, yi_q, k_q, l_q;
	logic              err_q;
	logic [DW_W-1:0]   dwidth_q, col_off_q;
	logic [AW-1:0]     col_addr_q, addr_q;

	// Output register
	logic              out_valid_q;
	logic [AW-1:0]     dest_addr_q;
	logic [pru_pkg::PIXEL_W-1:0] pixel_out_q;
	logic              is_error_q, last_q;

	// Clamped configuration
	logic [SIDE_W-1:0] w_eff, h_eff;
	logic [FACT_W-1:0] xf_eff, yf_eff, xi_eff, yi_eff;
	logic [STEP_W-1:0] row_step;

	always_comb begin
		if (src_width_q == '0) begin
			w_eff = SIDE_W'(1);
		end else if (32'(src_width_q) > 32'(MAX_SIDE)) begin
			w_eff = SIDE_W'(MAX_SIDE);
		end else begin
			w_eff = SIDE_W'(src_width_q);
		end
		if (src_height_q == '0) begin
			h_eff = SIDE_W'(1);
		end else if (32'(src_height_q) > 32'(MAX_SIDE)) begin
			h_eff = SIDE_W'(MAX_SIDE);
		end else begin
			h_eff = SIDE_W'(src_height_q);
		end
		if (x_factor_q == '0) begin
			xf_eff = FACT_W'(1);
		end else if (32'(x_factor_q) > 32'(MAX_FACTOR)) begin
			xf_eff = FACT_W'(MAX_FACTOR);
		end else begin
			xf_eff = FACT_W'(x_factor_q);
		end
		if (y_factor_q == '0) begin
			yf_eff = FACT_W'(1);
		end else if (32'(y_factor_q) > 32'(MAX_FACTOR)) begin
			yf_eff = FACT_W'(MAX_FACTOR);
		end else begin
			yf_eff = FACT_W'(y_factor_q);
		end
		// columns and rows actually written in each block
		xi_eff = (32'(x_gap_q) < 32'(xf_eff)) ? xf_eff - FACT_W'(x_gap_q) : '0;
		yi_eff = (32'(y_gap_q) < 32'(yf_eff)) ? yf_eff - FACT_W'(y_gap_q) : '0;
	end

	// destination distance from one block row to the next
	assign row_step = STEP_W'(dwidth_q) * STEP_W'(yf_q);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= pru_pkg::SRC_WIDTH_RST;
			src_height_q <= pru_pkg::SRC_HEIGHT_RST;
			x_factor_q   <= pru_pkg::X_FACTOR_RST;
			y_factor_q   <= pru_pkg::Y_FACTOR_RST;
			x_gap_q      <= pru_pkg::X_GAP_RST;
			y_gap_q      <= pru_pkg::Y_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pru_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				pru_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data;
				pru_pkg::REG_X_FACTOR:   x_factor_q   <= cfg_data[pru_pkg::FACT_CFG_W-1:0];
				pru_pkg::REG_Y_FACTOR:   y_factor_q   <= cfg_data[pru_pkg::FACT_CFG_W-1:0];
				pru_pkg::REG_X_GAP:      x_gap_q      <= cfg_data[pru_pkg::GAP_CFG_W-1:0];
				pru_pkg::REG_Y_GAP:      y_gap_q      <= cfg_data[pru_pkg::GAP_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Column, row and block row base, advanced once per non-error item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
		end else if (cmd.base && !err_q) begin
			if (SIDE_W'(col_q) + SIDE_W'(1) >= w_q) begin
				col_q <= '0;
				if (SIDE_W'(row_q) + SIDE_W'(1) >= h_q) begin
					row_q      <= '0;
					row_base_q <= '0;
				end else begin
					row_q      <= row_q + CNT_W'(1);
					row_base_q <= row_base_q + AW'(row_step);
				end
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// Item capture and setup
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= pixel_in & PIX_MASK;
		end
		if (cmd.prep) begin
			w_q       <= w_eff;
			h_q       <= h_eff;
			yf_q      <= yf_eff;
			xi_q      <= xi_eff;
			yi_q      <= yi_eff;
			err_q     <= (xf_eff == FACT_W'(1)) && (yf_eff == FACT_W'(1));
			dwidth_q  <= DW_W'(w_eff) * DW_W'(xf_eff);
			col_off_q <= DW_W'(col_q) * DW_W'(xf_eff);
		end
		// Walk: column offset outer, row offset inner
		if (cmd.base) begin
			col_addr_q <= row_base_q + AW'(col_off_q);
			addr_q     <= row_base_q + AW'(col_off_q);
			k_q        <= '0;
			l_q        <= '0;
		end else if (cmd.emit) begin
			if (l_q + FACT_W'(1) == yi_q) begin
				l_q        <= '0;
				k_q        <= k_q + FACT_W'(1);
				col_addr_q <= col_addr_q + AW'(1);
				addr_q     <= col_addr_q + AW'(1);
			end else begin
				l_q    <= l_q + FACT_W'(1);
				addr_q <= addr_q + AW'(dwidth_q);
			end
		end
	end

	assign sts.err = err_q;
	assign sts.none = (xi_q == '0) || (yi_q == '0);
	assign sts.at_last = err_q || ((k_q + FACT_W'(1) == xi_q) && (l_q + FACT_W'(1) == yi_q));
	assign sts.out_free = !out_valid_q || out_ready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (err_q) begin
				dest_addr_q <= '0;
				pixel_out_q <= '0;
				is_error_q  <= 1'b1;
			end else begin
				dest_addr_q <= addr_q;
				pixel_out_q <= pix_q;
				is_error_q  <= 1'b0;
			end
			last_q <= sts.at_last;
		end
	end

	assign out_valid = out_valid_q;
	assign dest_addr = dest_addr_q;
	assign pixel_out = pixel_out_q;
	assign is_error  = is_error_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	// A write never overruns a result still waiting to be taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("output register overrun");

	// Block walk stays inside the written part of the block
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && !err_q |-> (k_q < xi_q) && (l_q < yi_q))
		else $error("block walk out of range");

	// Rejected items carry no write
	a_error_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && is_error_q |-> last_q && (dest_addr_q == '0) && (pixel_out_q == '0))
		else $error("error result carries a write");

	// Frame position stays below the largest side
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < 32'(MAX_SIDE)) && (32'(row_q) < 32'(MAX_SIDE)))
		else $error("frame position beyond maximum side");
`endif

endmodule

`default_nettype wire

FILE: sv/pixel_replication_upscaler_unit.sv
// Pixel replication upscaler. Source pixels come in raster order on the input
// channel; each is copied into an x_factor by y_factor block of the destination
// framebuffer (row pitch src_width*x_factor), skipping the last x_gap columns
// and y_gap rows of the block. Writes leave column offset outer, row offset
// inner, with last set on the final write of each pixel. Both factors at one
// gives a single is_error result and no write; a gap at least its factor gives
// no result at all, though the position still advances. One pixel is handled
// at a time: it is set up first (factor products, then block base address and
// position update), then one cycle per write while the output drains, then it
// returns to idle, where the next pixel is taken.
`default_nettype none

module pixel_replication_upscaler_unit #(
	parameter int PIXEL_BITS = pru_pkg::PIXEL_BITS_DEF,
	parameter int MAX_SIDE = pru_pkg::MAX_SIDE_DEF,
	parameter int MAX_FACTOR = pru_pkg::MAX_FACTOR_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pru_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [pru_pkg::PIXEL_W-1:0]    pixel_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [pru_pkg::ADDR_W-1:0]          dest_addr,
	output logic [pru_pkg::PIXEL_W-1:0]         pixel_out,
	output logic                                is_error,
	output logic                                last
);

	pru_pkg::pru_cmd_t cmd;
	pru_pkg::pru_sts_t sts;

	// Sequencer
	pru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Address generation, position counters and output register
	pru_datapath #(
		.PIXEL_BITS (PIXEL_BITS),
		.MAX_SIDE   (MAX_SIDE),
		.MAX_FACTOR (MAX_FACTOR)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel_in  (pixel_in),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.dest_addr (dest_addr),
		.pixel_out (pixel_out),
		.is_error  (is_error),
		.last      (last),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int CLK_HALF = 5;
	localparam int RESET_CYCLES = 8;
	localparam int ITEMS_TOTAL = 460;
	localparam int QUIET_ITEMS = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 20000;
	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int STIM_ROWS = 24;
	localparam logic [pru_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam logic [pru_pkg::PIXEL_W-1:0] PIX_MASK =
		pru_pkg::PIXEL_W'((64'd1 << pru_pkg::PIXEL_BITS_DEF) - 1);

	// One framebuffer write as seen on the output channel
	typedef struct packed {
		logic [pru_pkg::ADDR_W-1:0]  addr;
		logic [pru_pkg::PIXEL_W-1:0] pix;
		logic                        err;
		logic                        last;
	} fb_write_t;

	// One full register setting
	typedef struct packed {
		logic [pru_pkg::SIDE_CFG_W-1:0] width;
		logic [pru_pkg::SIDE_CFG_W-1:0] height;
		logic [pru_pkg::FACT_CFG_W-1:0] x_factor;
		logic [pru_pkg::FACT_CFG_W-1:0] y_factor;
		logic [pru_pkg::GAP_CFG_W-1:0]  x_gap;
		logic [pru_pkg::GAP_CFG_W-1:0]  y_gap;
	} setting_t;

	typedef enum logic [1:0] {PREDICT, EXPECT_ERROR, EXPECT_NONE} row_kind_t;

	typedef struct packed {
		logic                        load;
		setting_t                    cfg;
		logic [pru_pkg::PIXEL_W-1:0] pix;
		row_kind_t                   kind;
	} stim_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [pru_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pru_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [pru_pkg::PIXEL_W-1:0]    pixel_in = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [pru_pkg::ADDR_W-1:0]     dest_addr;
	logic [pru_pkg::PIXEL_W-1:0]    pixel_out;
	logic                           is_error;
	logic                           last;

	// Predictor copy of the registers and the raster position
	logic [pru_pkg::SIDE_CFG_W-1:0] cfg_width;
	logic [pru_pkg::SIDE_CFG_W-1:0] cfg_height;
	logic [pru_pkg::FACT_CFG_W-1:0] cfg_x_factor;
	logic [pru_pkg::FACT_CFG_W-1:0] cfg_y_factor;
	logic [pru_pkg::GAP_CFG_W-1:0]  cfg_x_gap;
	logic [pru_pkg::GAP_CFG_W-1:0]  cfg_y_gap;
	int unsigned                    col_pos;
	int unsigned                    row_pos;
	logic [pru_pkg::ADDR_W-1:0]     row_addr;

	fb_write_t   pixel_writes[$];
	fb_write_t   awaited_writes[$];
	stim_row_t   stim_rows [STIM_ROWS];
	int          fail_count = 0;
	int          items_sent = 0;
	int unsigned cycle_count = 0;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	int          rx_stall = 0;

	pixel_replication_upscaler_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dest_addr (dest_addr),
		.pixel_out (pixel_out),
		.is_error  (is_error),
		.last      (last)
	);

	always #CLK_HALF clk = ~clk;

	task automatic flag_mismatch(input string msg);
		fail_count++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	function automatic int unsigned clamp_to(input int unsigned v, input int unsigned hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Register write as the block sees it
	function automatic void apply_reg(input logic [pru_pkg::CFG_IDX_W-1:0] idx,
			input logic [pru_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			pru_pkg::REG_SRC_WIDTH:  cfg_width = data[pru_pkg::SIDE_CFG_W-1:0];
			pru_pkg::REG_SRC_HEIGHT: cfg_height = data[pru_pkg::SIDE_CFG_W-1:0];
			pru_pkg::REG_X_FACTOR:   cfg_x_factor = data[pru_pkg::FACT_CFG_W-1:0];
			pru_pkg::REG_Y_FACTOR:   cfg_y_factor = data[pru_pkg::FACT_CFG_W-1:0];
			pru_pkg::REG_X_GAP:      cfg_x_gap = data[pru_pkg::GAP_CFG_W-1:0];
			pru_pkg::REG_Y_GAP:      cfg_y_gap = data[pru_pkg::GAP_CFG_W-1:0];
			default: ;
		endcase
	endfunction

	// Writes one source pixel makes, then the raster position advance
	function automatic void upscale_pixel(input logic [pru_pkg::PIXEL_W-1:0] pix);
		int unsigned w, h, xf, yf, cols, rows, n;
		longint unsigned pitch, a;
		pixel_writes.delete();
		w = clamp_to(cfg_width, pru_pkg::MAX_SIDE_DEF);
		h = clamp_to(cfg_height, pru_pkg::MAX_SIDE_DEF);
		xf = clamp_to(cfg_x_factor, pru_pkg::MAX_FACTOR_DEF);
		yf = clamp_to(cfg_y_factor, pru_pkg::MAX_FACTOR_DEF);
		pitch = longint'(w) * xf;
		// 1x1 is refused outright; position stays put
		if (xf == 1 && yf == 1) begin
			pixel_writes.push_back('{addr: '0, pix: '0, err: 1'b1, last: 1'b1});
			return;
		end
		cols = (cfg_x_gap < xf) ? xf - cfg_x_gap : 0;
		rows = (cfg_y_gap < yf) ? yf - cfg_y_gap : 0;
		n = 0;
		for (int unsigned k = 0; k < cols; k++) begin
			for (int unsigned l = 0; l < rows; l++) begin
				a = longint'(row_addr) + longint'(col_pos) * xf + k + pitch * l;
				n++;
				pixel_writes.push_back('{addr: a[pru_pkg::ADDR_W-1:0],
						pix: pix & PIX_MASK, err: 1'b0, last: (n == cols * rows)});
			end
		end
		// Wrap column, then row, at frame end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				row_pos = 0;
				row_addr = '0;
			end else begin
				row_pos++;
				row_addr = pru_pkg::ADDR_W'(longint'(row_addr) + pitch * yf);
			end
		end else begin
			col_pos++;
		end
	endfunction

	task automatic write_reg(input logic [pru_pkg::CFG_IDX_W-1:0] idx,
			input logic [pru_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
	endtask

	// Whole setting; spare upper data bits carry junk
	task automatic load_setting(input setting_t s, input bit poke_spare);
		write_reg(pru_pkg::REG_SRC_WIDTH, s.width);
		write_reg(pru_pkg::REG_SRC_HEIGHT, s.height);
		write_reg(pru_pkg::REG_X_FACTOR, {8'($urandom_range(0, 255)), s.x_factor});
		write_reg(pru_pkg::REG_Y_FACTOR, {8'($urandom_range(0, 255)), s.y_factor});
		write_reg(pru_pkg::REG_X_GAP, {9'($urandom_range(0, 511)), s.x_gap});
		write_reg(pru_pkg::REG_Y_GAP, {9'($urandom_range(0, 511)), s.y_gap});
		if (poke_spare)
			write_reg(REG_NONE, 12'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly small frames and sane gaps; now and then anything the fields hold
	function automatic setting_t random_setting();
		setting_t s;
		s.width = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(1, 12));
		s.height = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(1, 6));
		s.x_factor = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
		s.y_factor = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
		s.x_gap = ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom);
		s.y_gap = ($urandom_range(0, 9) < 7) ? 3'd0 : 3'($urandom);
		return s;
	endfunction

	task automatic send_pixel(input logic [pru_pkg::PIXEL_W-1:0] pix, input row_kind_t kind);
		int gap;
		gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		pixel_in <= pix;
		do @(posedge clk); while (!in_ready);
		upscale_pixel(pix);
		case (kind)
			PREDICT:      foreach (pixel_writes[j]) awaited_writes.push_back(pixel_writes[j]);
			EXPECT_ERROR: awaited_writes.push_back('{addr: '0, pix: '0, err: 1'b1, last: 1'b1});
			EXPECT_NONE:  ;
			default:      ;
		endcase
		items_sent++;
	endtask

	// Hold off until every write is out, plus time for a silent pixel
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_writes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (awaited_writes.size() != 0) begin
			flag_mismatch($sformatf("%0d writes never arrived", awaited_writes.size()));
			awaited_writes.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver stalls in bursts
	always @(negedge clk) begin
		if (!rx_idle_en) begin
			rx_stall = 0;
			out_ready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_stall = $urandom_range(1, 13) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Output checker
	always @(posedge clk) begin : write_check
		fb_write_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_writes.size() == 0) begin
				flag_mismatch($sformatf("unexpected write addr %h pix %h err %b",
						dest_addr, pixel_out, is_error));
			end else begin
				want = awaited_writes.pop_front();
				if (dest_addr !== want.addr)
					flag_mismatch($sformatf("dest_addr %h, want %h", dest_addr, want.addr));
				if (pixel_out !== want.pix)
					flag_mismatch($sformatf("pixel_out %h, want %h", pixel_out, want.pix));
				if (is_error !== want.err)
					flag_mismatch($sformatf("is_error %b, want %b", is_error, want.err));
				if (last !== want.last)
					flag_mismatch($sformatf("last %b, want %b at addr %h",
							last, want.last, want.addr));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		bit first_phase;
		first_phase = 1'b1;

		// Directed rows: {load, {w, h, xf, yf, xgap, ygap}, pixel, check}
		stim_rows = '{
			// after reset, 320x200 at 2x2
			'{1'b0, '0, 32'hFFFF_FFFF, PREDICT},
			'{1'b0, '0, 32'h0000_0000, PREDICT},
			// 1x1 refused, position held
			'{1'b1, '{12'd2, 12'd2, 4'd1, 4'd1, 3'd0, 3'd0}, 32'hA5A5_A5A5, EXPECT_ERROR},
			'{1'b0, '0, 32'h5A5A_5A5A, EXPECT_ERROR},
			// zero factor clamps to one
			'{1'b1, '{12'd2, 12'd2, 4'd0, 4'd1, 3'd0, 3'd0}, 32'hFFFF_FFFF, EXPECT_ERROR},
			// largest block, column beyond the narrowed width
			'{1'b1, '{12'd2, 12'd2, 4'd8, 4'd8, 3'd0, 3'd0}, 32'h1234_5678, PREDICT},
			'{1'b0, '0, 32'h8765_4321, PREDICT},
			'{1'b1, '{12'd2, 12'd2, 4'd8, 4'd8, 3'd7, 3'd7}, 32'hFFFF_0000, PREDICT},
			// gap swallows the block
			'{1'b1, '{12'd2, 12'd2, 4'd2, 4'd2, 3'd2, 3'd0}, 32'h0000_FFFF, EXPECT_NONE},
			'{1'b0, '0, 32'hDEAD_BEEF, EXPECT_NONE},
			'{1'b1, '{12'd2, 12'd2, 4'd3, 4'd3, 3'd0, 3'd7}, 32'hCAFE_F00D, EXPECT_NONE},
			// oversize values clamp
			'{1'b1, '{12'hFFF, 12'hFFF, 4'd15, 4'd15, 3'd0, 3'd0}, 32'h0000_0001, PREDICT},
			'{1'b0, '0, 32'h8000_0000, PREDICT},
			// zero sizes clamp to one
			'{1'b1, '{12'd0, 12'd0, 4'd9, 4'd2, 3'd0, 3'd1}, 32'h7FFF_FFFF, PREDICT},
			// 3x2 frame, wraps after six pixels
			'{1'b1, '{12'd3, 12'd2, 4'd1, 4'd4, 3'd0, 3'd1}, 32'h1111_1111, PREDICT},
			'{1'b0, '0, 32'h2222_2222, PREDICT},
			'{1'b0, '0, 32'h3333_3333, PREDICT},
			'{1'b0, '0, 32'h4444_4444, PREDICT},
			'{1'b0, '0, 32'h5555_5555, PREDICT},
			'{1'b0, '0, 32'h6666_6666, PREDICT},
			'{1'b1, '{12'd3, 12'd2, 4'd4, 4'd1, 3'd3, 3'd0}, 32'h7777_7777, PREDICT},
			'{1'b1, '{12'd2048, 12'd1, 4'd1, 4'd2, 3'd0, 3'd0}, 32'h8888_8888, PREDICT},
			'{1'b1, '{12'd1, 12'd2048, 4'd3, 4'd1, 3'd1, 3'd0}, 32'h9999_9999, PREDICT},
			'{1'b1, '{12'd5, 12'd3, 4'd2, 4'd2, 3'd1, 3'd1}, 32'hAAAA_AAAA, PREDICT}
		};

		// Reset state
		cfg_width = pru_pkg::SRC_WIDTH_RST;
		cfg_height = pru_pkg::SRC_HEIGHT_RST;
		cfg_x_factor = pru_pkg::X_FACTOR_RST;
		cfg_y_factor = pru_pkg::Y_FACTOR_RST;
		cfg_x_gap = pru_pkg::X_GAP_RST;
		cfg_y_gap = pru_pkg::Y_GAP_RST;
		col_pos = 0;
		row_pos = 0;
		row_addr = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part
		for (int i = 0; i < STIM_ROWS; i++) begin
			if (stim_rows[i].load) begin
				settle();
				load_setting(stim_rows[i].cfg, 1'b0);
			end
			send_pixel(stim_rows[i].pix, stim_rows[i].kind);
		end

		// Random phases, each under a fresh setting
		while (items_sent < ITEMS_TOTAL - QUIET_ITEMS) begin
			settle();
			load_setting(random_setting(), first_phase);
			first_phase = 1'b0;
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(10, 40)) send_pixel($urandom, PREDICT);
		end

		// Closing stretch at full rate
		settle();
		load_setting(random_setting(), 1'b0);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (QUIET_ITEMS) send_pixel($urandom, PREDICT);
		settle();

		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
